>>> hw/rtl/go_to_goal_velocity_controller_unit_assert.svh
// Assertion macros for the go-to-goal controller modules.
// Needs no other file; included by the top level, which checks its own logic.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_UNIT_ASSERT_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define G2G_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define G2G_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hw/rtl/g2g_pkg.sv
// Package of the go-to-goal controller: widths, pipeline depth, CORDIC table.
// Depends on nothing.
package g2g_pkg;
	localparam int Steps = 16;
	localparam int SqrtSteps = 17;
	localparam int Depth = SqrtSteps + 3;
	localparam logic signed [19:0] PiQ16 = 20'sd205887;

	typedef enum logic [2:0] {
		REG_TARGET_X = 3'd0,
		REG_TARGET_Y = 3'd1,
		REG_GAIN     = 3'd2,
		REG_MAX_SPD  = 3'd3,
		REG_DIST_TH  = 3'd4,
		REG_ANG_TH   = 3'd5
	} reg_idx_t;

	// One cell's payload: CORDIC vector and angle, square-root state, pose.
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [20:0] z;
		logic [35:0]        rem;
		logic [17:0]        root;
		logic signed [12:0] heading;
	} cell_t;

	function automatic logic signed [20:0] atan_q16(input int i);
		logic signed [20:0] t;
		unique case (i)
			0: t = 21'sd51472;   1: t = 21'sd30385;  2: t = 21'sd16055;
			3: t = 21'sd8150;    4: t = 21'sd4091;   5: t = 21'sd2047;
			6: t = 21'sd1024;    7: t = 21'sd512;    8: t = 21'sd256;
			9: t = 21'sd128;     10: t = 21'sd64;    11: t = 21'sd32;
			12: t = 21'sd16;     13: t = 21'sd8;     14: t = 21'sd4;
			15: t = 21'sd2;      default: t = '0;
		endcase
		return t;
	endfunction
endpackage

>>> hw/rtl/g2g_if.sv
// Valid/ready channel interfaces for pose and command items.
// Depends on nothing.
interface g2g_pose_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [12:0] heading;
	modport source (output valid, pos_x, pos_y, heading, input ready);
	modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface g2g_cmd_if;
	logic               valid;
	logic               ready;
	logic [14:0]        linear_speed;
	logic signed [15:0] angular_speed;
	modport source (output valid, linear_speed, angular_speed, input ready);
	modport sink (input valid, linear_speed, angular_speed, output ready);
endinterface

>>> hw/rtl/g2g_cell.sv
// One cell of the chain: a CORDIC vectoring step and a square-root digit step.
// Depends on g2g_pkg.
module g2g_cell
	import g2g_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  logic  [4:0] idx,
	input  cell_t d,
	output cell_t q
);
	cell_t n;
	logic signed [33:0] xs, ys;
	logic [35:0] trial;
	logic [5:0] sh;
	always_comb begin
		n = d;
		xs = d.x >>> idx;
		ys = d.y >>> idx;
		if (idx < 5'(Steps)) begin
			if (d.y >= 0) begin
				n.x = d.x + ys; n.y = d.y - xs; n.z = d.z + atan_q16(int'(idx));
			end else begin
				n.x = d.x - ys; n.y = d.y + xs; n.z = d.z - atan_q16(int'(idx));
			end
		end
		// Restoring square root: bit (16-idx) of the root, rem holds v - r^2.
		sh = 6'(32 - 2 * int'(idx));
		trial = ({18'd0, d.root} << (6'(17) - {1'b0, idx})) + (36'd1 << sh);
		if (d.rem >= trial) begin
			n.rem = d.rem - trial;
			n.root = d.root | (18'd1 << (5'd16 - idx));
		end
	end
	always_ff @(posedge clk) begin
		if (en) q <= n;
	end
endmodule

>>> hw/rtl/go_to_goal_velocity_controller_unit.sv
// Top level of the go-to-goal proportional velocity controller.
// Depends on g2g_pkg, g2g_if, g2g_cell and the assertion header.
//
// Use: pose items enter on the pose sink channel, one velocity command
// leaves per pose on the command source channel, in order.
// The datapath is a chain of 17 identical cells; each does one CORDIC
// rotation (first 16) and one digit of the integer square root. An entry
// stage forms dx, dy and the squared distance; a decision stage applies the
// thresholds, and an output stage applies gain and saturation into the
// output register. There are 20 register stages, the first loaded at the
// accepting edge. Throughput is one item per cycle: the whole chain advances
// whenever the output register is empty or being taken, so ready is low
// only while the receiver stalls with a full output register. A stall
// freezes every stage in place.
// Reset clears all valid bits and loads the register defaults: target
// (1.0, 1.0), gain 1.0, max speed 3.0, both thresholds 102. Configuration
// must be written over the APB port only while idle, which the block does
// not enforce. Registers are at byte addresses 4*i; reads give stored values.
`include "go_to_goal_velocity_controller_unit_assert.svh"
module go_to_goal_velocity_controller_unit
	import g2g_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	g2g_pose_if.sink    pose,
	g2g_cmd_if.source   cmd,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic signed [15:0] tx_q, ty_q;
	logic [15:0] gain_q;
	logic [14:0] max_q, dth_q, ath_q;
	reg_idx_t ridx;
	logic wr;

	assign pready = 1'b1;
	assign ridx = reg_idx_t'(paddr[4:2]);
	assign wr = psel && penable && pwrite && (paddr[4:2] <= 3'd5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q <= 16'sd1024; ty_q <= 16'sd1024; gain_q <= 16'd256;
			max_q <= 15'd3072; dth_q <= 15'd102; ath_q <= 15'd102;
		end else if (wr) begin
			unique case (ridx)
				REG_TARGET_X: tx_q <= pwdata[15:0];
				REG_TARGET_Y: ty_q <= pwdata[15:0];
				REG_GAIN:     gain_q <= pwdata[15:0];
				REG_MAX_SPD:  max_q <= pwdata[14:0];
				REG_DIST_TH:  dth_q <= pwdata[14:0];
				REG_ANG_TH:   ath_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[4:2] <= 3'd5) begin
			unique case (ridx)
				REG_TARGET_X: prdata = {{16{tx_q[15]}}, tx_q};
				REG_TARGET_Y: prdata = {{16{ty_q[15]}}, ty_q};
				REG_GAIN:     prdata = {16'd0, gain_q};
				REG_MAX_SPD:  prdata = {17'd0, max_q};
				REG_DIST_TH:  prdata = {17'd0, dth_q};
				REG_ANG_TH:   prdata = {17'd0, ath_q};
				default: ;
			endcase
		end
	end

	// Pipeline advance: everything moves unless the output is full and held.
	logic adv;
	logic [Depth-1:0] vld_q;
	assign adv = !cmd.valid || cmd.ready;
	assign pose.ready = adv;

	// Entry stage.
	logic signed [16:0] dx, dy;
	logic [33:0] dsq;
	cell_t ent;
	cell_t chain [SqrtSteps+1];
	assign dx = 17'(tx_q) - 17'(pose.pos_x);
	assign dy = 17'(ty_q) - 17'(pose.pos_y);
	assign dsq = 34'(dx * dx) + 34'(dy * dy);
	always_comb begin
		ent.x = 34'(dx) <<< 10;
		ent.y = 34'(dy) <<< 10;
		ent.z = '0;
		if (dx < 0) begin
			ent.x = -ent.x; ent.y = -ent.y;
			ent.z = (dy >= 0) ? 21'(PiQ16) : -21'(PiQ16);
		end
		ent.rem = 36'(dsq);
		ent.root = '0;
		ent.heading = pose.heading;
	end
	always_ff @(posedge clk) begin
		if (adv) chain[0] <= ent;
	end

	for (genvar g = 0; g < SqrtSteps; g++) begin : g_cell
		g2g_cell u_cell (.clk(clk), .en(adv), .idx(5'(g)), .d(chain[g]), .q(chain[g+1]));
	end

	// Decision stage: form bearing error and pick mode.
	cell_t fin;
	logic signed [21:0] bear, err;
	logic [21:0] mag;
	logic drive_s1, turn_s1;
	logic signed [21:0] err_s1;
	logic [17:0] d_s1;
	assign fin = chain[SqrtSteps];
	assign bear = (22'(fin.z) + 22'sd32) >>> 6;
	assign err = bear - 22'(fin.heading);
	assign mag = err[21] ? 22'(-err) : 22'(err);
	always_ff @(posedge clk) begin
		if (adv) begin
			turn_s1 <= (fin.root > 18'(dth_q)) && (mag > 22'(ath_q));
			drive_s1 <= (fin.root > 18'(dth_q)) && !(mag > 22'(ath_q));
			err_s1 <= err;
			d_s1 <= fin.root;
		end
	end

	// Output stage.
	logic signed [39:0] pa;
	logic [34:0] pl;
	logic signed [39:0] ar;
	logic [34:0] lr;
	logic [14:0] lin_nxt;
	logic signed [15:0] ang_nxt;
	assign pa = 40'(err_s1) * $signed({24'd0, gain_q});
	assign pl = 35'(d_s1) * 35'(gain_q);
	assign ar = (pa + 40'sd128) >>> 8;
	assign lr = (pl + 35'd128) >> 8;
	always_comb begin
		lin_nxt = '0;
		ang_nxt = '0;
		if (turn_s1) begin
			if (ar > 40'sd32767) ang_nxt = 16'sh7fff;
			else if (ar < -40'sd32768) ang_nxt = 16'sh8000;
			else ang_nxt = ar[15:0];
		end else if (drive_s1) begin
			lin_nxt = (lr > 35'(max_q)) ? max_q : lr[14:0];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd.linear_speed <= lin_nxt;
			cmd.angular_speed <= ang_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[Depth-2:0], pose.valid};
	end
	assign cmd.valid = vld_q[Depth-1];

	`G2G_ASSERT_NXT(a_stall_hold, clk, arst_n, cmd.valid && !cmd.ready, cmd.valid, "command lost during stall")
	`G2G_ASSERT_IMP(a_ready, clk, arst_n, !cmd.valid, pose.ready, "ready low with empty output")
	`G2G_ASSERT_NXT(a_flow, clk, arst_n, adv && vld_q[Depth-2], cmd.valid, "item dropped at exit")
endmodule

>>> tb/sv/tb_top.sv
// Testbench for the go-to-goal velocity controller: directed poses, then random ones.
// Depends on g2g_pkg, the g2g_if channel interfaces and the controller top level.
`timescale 1ns / 100ps
module tb_top;
	import g2g_pkg::*;

	localparam int ClkHalf = 6;
	localparam int Latency = 20;
	localparam int RandomPerPhase = 100;
	// Register slots past the last one; writes there must change nothing.
	localparam int RegSpareA = 6;
	localparam int RegSpareB = 7;

	typedef struct {
		logic [14:0]        lin;
		logic signed [15:0] ang;
	} velocity_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [12:0] h;
		bit                 typed;
		velocity_t          want;
	} pose_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	g2g_pose_if pose();
	g2g_cmd_if cmd();

	go_to_goal_velocity_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose(pose.sink),
		.cmd(cmd.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Our own copy of the controller settings, kept in step with every register write.
	longint goal_x, goal_y, gain_q8, speed_cap, arrive_radius, aim_tolerance;

	// Rounded atan(2^-i) in Q.16 for the bearing rotations.
	longint arctan_q16 [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	velocity_t cmd_queue[$];	// commands still owed, oldest first
	int mismatches;
	bit idle_on;
	bit directed_now;
	velocity_t directed_want;
	bit directed_typed;

	initial begin
		clk = 1'b0;
		forever #ClkHalf clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 40;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Bearing of (dx, dy) in Q5.10 radians by vectoring rotations; >>> floors.
	function automatic longint goal_bearing(longint dx, longint dy);
		longint cx, cy, z, xs, ys;
		cx = dx * 1024;
		cy = dy * 1024;
		z = 0;
		if (cx < 0) begin
			z = (cy >= 0) ? 205887 : -205887;
			cx = -cx;
			cy = -cy;
		end
		for (int i = 0; i < 16; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (cy >= 0) begin
				cx = cx + ys;
				cy = cy - xs;
				z = z + arctan_q16[i];
			end else begin
				cx = cx - ys;
				cy = cy + xs;
				z = z - arctan_q16[i];
			end
		end
		return (z + 32) >>> 6;
	endfunction

	// Velocity command for one pose under the current settings.
	function automatic velocity_t steer_toward_goal(logic signed [15:0] px,
		logic signed [15:0] py, logic signed [12:0] hd);
		velocity_t v;
		longint dx, dy, span, err, mag, a, l;
		v.lin = '0;
		v.ang = '0;
		dx = goal_x - longint'(px);
		dy = goal_y - longint'(py);
		span = floor_sqrt(dx * dx + dy * dy);
		if (span > arrive_radius) begin
			err = goal_bearing(dx, dy) - longint'(hd);
			mag = (err < 0) ? -err : err;
			if (mag > aim_tolerance) begin
				a = (gain_q8 * err + 128) >>> 8;
				if (a > 32767) a = 32767;
				if (a < -32768) a = -32768;
				v.ang = a[15:0];
			end else begin
				l = (gain_q8 * span + 128) >>> 8;
				if (l > speed_cap) l = speed_cap;
				v.lin = l[14:0];
			end
		end
		return v;
	endfunction

	// Pose acceptance: the expectation is formed from the settings in force right now.
	always @(posedge clk) begin
		if (pose.valid && pose.ready) begin
			if (directed_now && directed_typed)
				cmd_queue.push_back(directed_want);
			else
				cmd_queue.push_back(steer_toward_goal(pose.pos_x, pose.pos_y, pose.heading));
		end
	end

	// Command acceptance: compare each field with the oldest expectation.
	always @(posedge clk) begin
		velocity_t w;
		if (cmd.valid && cmd.ready) begin
			if (cmd_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected command lin=%0d ang=%0d",
						cmd.linear_speed, cmd.angular_speed);
			end else begin
				w = cmd_queue.pop_front();
				if (w.lin !== cmd.linear_speed || w.ang !== cmd.angular_speed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("command mismatch: expected lin=%0d ang=%0d, got lin=%0d ang=%0d",
							w.lin, w.ang, cmd.linear_speed, cmd.angular_speed);
				end
			end
		end
	end

	// The receiver stalls in random bursts while idling is on.
	initial begin
		cmd.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				cmd.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			cmd.ready <= 1'b1;
		end
	end

	// One register write over the APB port: setup cycle, then access cycle.
	task automatic write_setting(int idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TARGET_X: goal_x = longint'($signed(value[15:0]));
			REG_TARGET_Y: goal_y = longint'($signed(value[15:0]));
			REG_GAIN:     gain_q8 = value[15:0];
			REG_MAX_SPD:  speed_cap = value[14:0];
			REG_DIST_TH:  arrive_radius = value[14:0];
			REG_ANG_TH:   aim_tolerance = value[14:0];
			default: ;
		endcase
	endtask

	// Send one pose, with an optional gap in front; valid stays high afterwards.
	task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
		logic signed [12:0] hd);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			pose.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		pose.valid <= 1'b1;
		pose.pos_x <= px;
		pose.pos_y <= py;
		pose.heading <= hd;
		do @(posedge clk); while (!pose.ready);
	endtask

	// The extra edge lets the monitor record the last accepted pose first.
	task automatic drain_commands();
		pose.valid <= 1'b0;
		@(posedge clk);
		while (cmd_queue.size() != 0) @(posedge clk);
	endtask

	// Random poses: many near the goal so the arrival, aiming and drive branches all fire.
	task automatic random_poses(int count);
		logic signed [15:0] px, py;
		logic signed [12:0] hd;
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				px = 16'(goal_x + $signed(17'($urandom_range(0, 1024))) - 512);
				py = 16'(goal_y + $signed(17'($urandom_range(0, 1024))) - 512);
			end else if (kind == 4) begin
				px = 16'(goal_x);
				py = 16'(goal_y);
			end else begin
				px = 16'($urandom);
				py = 16'($urandom);
			end
			if ($urandom_range(0, 9) == 0)
				hd = 13'($urandom);	// any 13-bit value, possibly outside plus or minus pi, used as given
			else
				hd = 13'($signed($urandom_range(0, 6434)) - 3217);
			// Sometimes aim the heading at the goal so the block drives.
			if ($urandom_range(0, 2) == 0)
				hd = 13'(goal_bearing(goal_x - px, goal_y - py)
					+ $signed($urandom_range(0, 40)) - 20);
			send_pose(px, py, hd);
		end
	endtask

	pose_row_t rows [] = '{
		// Pose exactly at the default goal: arrived, both outputs zero.
		'{16'sd1024, 16'sd1024, 13'sd0, 1'b1, '{15'd0, 16'sd0}},
		'{16'sd1024, 16'sd1024, -13'sd3217, 1'b1, '{15'd0, 16'sd0}},
		// Goal straight ahead one unit away: drive at gain times distance.
		'{16'sd0, 16'sd1024, 13'sd0, 1'b1, '{15'd1024, 16'sd0}},
		// Far corner with heading along the diagonal: drive clipped to max speed.
		'{-16'sd32768, -16'sd32768, 13'sd804, 1'b1, '{15'd3072, 16'sd0}},
		'{16'sd32767, 16'sd32767, 13'sd0, 1'b0, '{15'd0, 16'sd0}},
		'{16'sd32767, -16'sd32768, 13'sd3217, 1'b0, '{15'd0, 16'sd0}},
		'{-16'sd32768, 16'sd32767, -13'sd3217, 1'b0, '{15'd0, 16'sd0}},
		// Bearing near pi with a heading near minus pi: large unwrapped error.
		'{16'sd2048, 16'sd1023, -13'sd3217, 1'b0, '{15'd0, 16'sd0}},
		'{16'sd2048, 16'sd1025, 13'sd3217, 1'b0, '{15'd0, 16'sd0}},
		// Headings beyond plus or minus pi.
		'{16'sd0, 16'sd0, 13'sd4095, 1'b0, '{15'd0, 16'sd0}},
		'{16'sd0, 16'sd0, -13'sd4096, 1'b0, '{15'd0, 16'sd0}},
		// Just inside and just outside the arrival radius.
		'{16'sd1126, 16'sd1024, 13'sd0, 1'b0, '{15'd0, 16'sd0}},
		'{16'sd1127, 16'sd1024, 13'sd0, 1'b0, '{15'd0, 16'sd0}},
		// Straight below and straight above the goal.
		'{16'sd1024, 16'sd0, 13'sd1608, 1'b0, '{15'd0, 16'sd0}},
		'{16'sd1024, 16'sd2048, -13'sd1608, 1'b0, '{15'd0, 16'sd0}},
		'{16'sd1024, 16'sd2048, 13'sd1, 1'b0, '{15'd0, 16'sd0}},
		'{-16'sd1, 16'sd0, -13'sd1, 1'b0, '{15'd0, 16'sd0}}
	};

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pose.valid <= 1'b0;
		pose.pos_x <= '0;
		pose.pos_y <= '0;
		pose.heading <= '0;
		goal_x = 1024;
		goal_y = 1024;
		gain_q8 = 256;
		speed_cap = 3072;
		arrive_radius = 102;
		aim_tolerance = 102;
		mismatches = 0;
		idle_on = 1'b1;
		directed_now = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset settings; typed rows carry their own answer.
		// The row flags change after the monitor has seen the previous acceptance.
		directed_now = 1'b1;
		foreach (rows[i]) begin
			directed_typed <= rows[i].typed;
			directed_want <= rows[i].want;
			send_pose(rows[i].x, rows[i].y, rows[i].h);
		end
		drain_commands();
		directed_now = 1'b0;
		random_poses(RandomPerPhase);
		drain_commands();

		// Extremes: maximum gain and speed, zero thresholds, goal in a far corner.
		// Upper data bits are set to show they are dropped.
		write_setting(REG_TARGET_X, 32'hFFFF_8000);
		write_setting(REG_TARGET_Y, 32'h0000_7FFF);
		write_setting(REG_GAIN, 32'h0001_FFFF);
		write_setting(REG_MAX_SPD, 32'hFFFF_7FFF);
		write_setting(REG_DIST_TH, 32'h0000_0000);
		write_setting(REG_ANG_TH, 32'h0000_0000);
		random_poses(RandomPerPhase);
		drain_commands();

		// Writes to slots beyond the register file must leave everything as is.
		write_setting(RegSpareA, $urandom);
		write_setting(RegSpareB, $urandom);
		write_setting(REG_TARGET_X, 32'h0000_7FFF);
		write_setting(REG_TARGET_Y, 32'h0000_8000);
		random_poses(RandomPerPhase / 2);
		drain_commands();

		// Widest thresholds and zero gain.
		write_setting(REG_GAIN, 32'h0000_0000);
		write_setting(REG_DIST_TH, 32'h0000_7FFF);
		write_setting(REG_ANG_TH, 32'h0000_7FFF);
		write_setting(REG_MAX_SPD, 32'h0000_0000);
		random_poses(RandomPerPhase / 2);
		drain_commands();

		// Random settings, mostly moderate so every branch gets work.
		for (int p = 0; p < 3; p++) begin
			write_setting(REG_TARGET_X, $urandom);
			write_setting(REG_TARGET_Y, $urandom);
			write_setting(REG_GAIN, $urandom);
			write_setting(REG_MAX_SPD, $urandom);
			write_setting(REG_DIST_TH, $urandom_range(0, 2047));
			write_setting(REG_ANG_TH, $urandom_range(0, 400));
			random_poses(RandomPerPhase);
			drain_commands();
		end

		// Last stretch at full rate on both sides.
		idle_on = 1'b0;
		write_setting(REG_GAIN, 32'd256);
		write_setting(REG_ANG_TH, 32'd102);
		random_poses(RandomPerPhase);
		drain_commands();
		repeat (Latency + 10) @(posedge clk);

		if (mismatches == 0 && cmd_queue.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
